// File: src/line_follow_pid_steer_assert.svh
// Assertion macros for the line follower steering block.
// Define NO_ASSERTIONS to compile them out.
`ifndef LINE_FOLLOW_PID_STEER_ASSERT_SVH
`define LINE_FOLLOW_PID_STEER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge, skipped while reset is asserted.
`define LFPS_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// Checked on every rising edge, reset included.
`define LFPS_ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: check failed");

`else

`define LFPS_ASSERT_RST(lbl, clk, rst_n, prop)
`define LFPS_ASSERT_CLK(lbl, clk, prop)

`endif

`endif

// File: src/lfps_pkg.sv
`timescale 1ns / 1ps

package lfps_pkg;

    localparam int REFL_W     = 7;
    localparam int LEVEL_W    = 7;
    localparam int GAIN_W     = 24;
    localparam int RUN_W      = 10;
    localparam int STEER_W    = 8;
    localparam int ERR_W      = 20;
    localparam int SUM_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int Q16_SHIFT  = 16;
    localparam int DIV_W      = LEVEL_W + Q16_SHIFT;
    localparam int DIV_STEPS  = DIV_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int Q_W        = DIV_W + 1;

    localparam int MUL_A_W    = GAIN_W + 1;
    localparam int PROD_W     = MUL_A_W + SUM_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int FRAC_W     = 24;
    localparam int STEER_Q_W  = ACC_W - FRAC_W;

    localparam int Q16_HALF    = 32768;
    localparam int ERR_LIMIT   = 262144;
    localparam int STEER_LIMIT = 100;

    localparam logic [LEVEL_W-1:0] WHITE_RST    = LEVEL_W'(100);
    localparam logic [LEVEL_W-1:0] BLACK_RST    = LEVEL_W'(0);
    localparam logic [GAIN_W-1:0]  GAIN_P_RST   = GAIN_W'(20480);
    localparam logic [GAIN_W-1:0]  GAIN_I_RST   = GAIN_W'(0);
    localparam logic [GAIN_W-1:0]  GAIN_D_RST   = GAIN_W'(256000);
    localparam logic [RUN_W-1:0]   RUN_LEN_RST  = RUN_W'(100);

    localparam logic [CFG_IDX_W-1:0] CFG_WHITE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LEN = CFG_IDX_W'(5);

    typedef enum logic [1:0] {
        MSEL_P,
        MSEL_I,
        MSEL_D
    } t_msel;

    typedef struct packed {
        logic  load;
        logic  div_step;
        logic  err_calc;
        logic  sum_calc;
        logic  mul_en;
        t_msel msel;
        logic  acc_en;
        logic  rnd;
        logic  finish;
    } t_cmd;

endpackage

// File: src/line_follow_pid_steer.sv
`timescale 1ns / 1ps

// PID steering for a reflectance line follower. Each input item is one
// reflectance sample and gives exactly one result item: steer in -100..100,
// a one-item dark_alert when the dark run count just reached its set length,
// and calib_fault when the white and black levels are equal. From acceptance
// to a loaded output register, an item passes the bit-serial restoring
// divider that normalizes the sample, then one shared 25x32 multiplier used
// three times for the P, I and D terms, then rounding and clamping. The next
// item can be taken once the result is in the output register, even while
// that result is still stalled; no sample is taken while one is in progress.
// Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data;
// the user must write them only while the block is idle, which the block
// does not enforce. Indexes past the last register are ignored.
module line_follow_pid_steer import lfps_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [REFL_W-1:0]         i_reflect,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [STEER_W-1:0] o_steer,
    output logic                      o_dark_alert,
    output logic                      o_calib_fault,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    logic [LEVEL_W-1:0] r_white_level;
    logic [LEVEL_W-1:0] r_black_level;
    logic [GAIN_W-1:0]  r_gain_p;
    logic [GAIN_W-1:0]  r_gain_i;
    logic [GAIN_W-1:0]  r_gain_d;
    logic [RUN_W-1:0]   r_run_len;
    t_cmd               cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white_level <= WHITE_RST;
            r_black_level <= BLACK_RST;
            r_gain_p      <= GAIN_P_RST;
            r_gain_i      <= GAIN_I_RST;
            r_gain_d      <= GAIN_D_RST;
            r_run_len     <= RUN_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WHITE:   r_white_level <= i_cfg_data[LEVEL_W-1:0];
                CFG_BLACK:   r_black_level <= i_cfg_data[LEVEL_W-1:0];
                CFG_GAIN_P:  r_gain_p      <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:  r_gain_i      <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:  r_gain_d      <= i_cfg_data[GAIN_W-1:0];
                CFG_RUN_LEN: r_run_len     <= i_cfg_data[RUN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lfps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    lfps_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_reflect         (i_reflect),
        .i_white_level     (r_white_level),
        .i_black_level     (r_black_level),
        .i_gain_p          (r_gain_p),
        .i_gain_i          (r_gain_i),
        .i_gain_d          (r_gain_d),
        .i_dark_run_length (r_run_len),
        .o_steer           (o_steer),
        .o_dark_alert      (o_dark_alert),
        .o_calib_fault     (o_calib_fault)
    );

endmodule

// File: src/lfps_ctrl.sv
`timescale 1ns / 1ps
`include "line_follow_pid_steer_assert.svh"

module lfps_ctrl import lfps_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_out_stall,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_ERR,
        S_SUM,
        S_MP,
        S_MI,
        S_MD,
        S_ACC,
        S_RND,
        S_FIN
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             in_take;
    logic             out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_take     = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.msel  = MSEL_P;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.err_calc = 1'b1;
                n_state        = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_calc = 1'b1;
                n_state        = S_MP;
            end
            S_MP: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MSEL_P;
                n_state      = S_MI;
            end
            S_MI: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MSEL_I;
                o_cmd.acc_en = 1'b1;
                n_state      = S_MD;
            end
            S_MD: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MSEL_D;
                o_cmd.acc_en = 1'b1;
                n_state      = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_state      = S_RND;
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    `LFPS_ASSERT_RST(a_take_starts_div, i_clk, i_rst_n, in_take |=> r_state == S_DIV)
    `LFPS_ASSERT_RST(a_valid_from_fin, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_FIN))
    `LFPS_ASSERT_CLK(a_div_cnt_range, i_clk, r_state == S_DIV |-> r_cnt < CNT_W'(DIV_STEPS))

endmodule

// File: src/lfps_dpath.sv
`timescale 1ns / 1ps
`include "line_follow_pid_steer_assert.svh"

module lfps_dpath import lfps_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic [REFL_W-1:0]         i_reflect,
    input  logic [LEVEL_W-1:0]        i_white_level,
    input  logic [LEVEL_W-1:0]        i_black_level,
    input  logic [GAIN_W-1:0]         i_gain_p,
    input  logic [GAIN_W-1:0]         i_gain_i,
    input  logic [GAIN_W-1:0]         i_gain_d,
    input  logic [RUN_W-1:0]          i_dark_run_length,
    output logic signed [STEER_W-1:0] o_steer,
    output logic                      o_dark_alert,
    output logic                      o_calib_fault
);

    localparam logic signed [Q_W:0]         E_HI = (Q_W+1)'(ERR_LIMIT);
    localparam logic signed [Q_W:0]         E_LO = -((Q_W+1)'(ERR_LIMIT));
    localparam logic signed [Q_W:0]         E_HALF = (Q_W+1)'(Q16_HALF);
    localparam logic signed [STEER_Q_W-1:0] S_HI = STEER_Q_W'(STEER_LIMIT);
    localparam logic signed [STEER_Q_W-1:0] S_LO = -(STEER_Q_W'(STEER_LIMIT));
    localparam logic [ACC_W-1:0]            RND_BIAS = {{(ACC_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}};
    localparam logic signed [ERR_W-1:0]     ERR_MAX = E_HI[ERR_W-1:0];
    localparam logic signed [ERR_W-1:0]     ERR_MIN = E_LO[ERR_W-1:0];
    localparam logic signed [STEER_W-1:0]   STR_MAX = S_HI[STEER_W-1:0];
    localparam logic signed [STEER_W-1:0]   STR_MIN = S_LO[STEER_W-1:0];

    // loop state
    logic signed [ERR_W-1:0] r_prev_err;
    logic signed [SUM_W-1:0] r_err_sum;
    logic [RUN_W-1:0]        r_dark_run;

    // per-item working registers
    logic [DIV_W-1:0]           r_quo;
    logic [LEVEL_W-1:0]         r_rem;
    logic [LEVEL_W-1:0]         r_den;
    logic                       r_neg;
    logic                       r_fault;
    logic                       r_alert;
    logic signed [ERR_W-1:0]    r_err;
    logic signed [ERR_W:0]      r_diff;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [STEER_Q_W-1:0] r_q;

    // output register
    logic signed [STEER_W-1:0] r_steer;
    logic                      r_alert_out;
    logic                      r_fault_out;

    logic signed [LEVEL_W:0] num_diff;
    logic signed [LEVEL_W:0] den_diff;
    logic [LEVEL_W:0]        num_neg_v;
    logic [LEVEL_W:0]        den_neg_v;
    logic [LEVEL_W-1:0]      num_mag;
    logic [LEVEL_W-1:0]      den_mag;
    logic [LEVEL_W:0]        lvl_sum;
    logic                    is_dark;
    logic [RUN_W-1:0]        run_inc;
    logic                    run_full;

    logic [LEVEL_W:0]        trial;
    logic [LEVEL_W:0]        trial_sub;
    logic                    trial_ge;

    logic signed [Q_W-1:0]   q_s;
    logic signed [Q_W:0]     e_full;
    logic signed [ERR_W-1:0] err_c;

    logic signed [SUM_W+1:0] s_full;
    logic signed [SUM_W-1:0] sum_c;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [SUM_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  prod_c;
    logic [ACC_W-1:0]          acc_b;
    logic signed [STEER_W-1:0] steer_c;

    assign num_diff  = signed'({1'b0, i_reflect}) - signed'({1'b0, i_black_level});
    assign den_diff  = signed'({1'b0, i_white_level}) - signed'({1'b0, i_black_level});
    assign num_neg_v = -num_diff;
    assign den_neg_v = -den_diff;
    assign num_mag   = num_diff[LEVEL_W] ? num_neg_v[LEVEL_W-1:0] : num_diff[LEVEL_W-1:0];
    assign den_mag   = den_diff[LEVEL_W] ? den_neg_v[LEVEL_W-1:0] : den_diff[LEVEL_W-1:0];

    // dark when brighter reading than the floor of the level midpoint
    assign lvl_sum  = {1'b0, i_white_level} + {1'b0, i_black_level};
    assign is_dark  = i_reflect > lvl_sum[LEVEL_W:1];
    assign run_inc  = r_dark_run + RUN_W'(1);
    assign run_full = &r_dark_run;

    // restoring divide, one quotient bit per step
    assign trial     = {r_rem, r_quo[DIV_W-1]};
    assign trial_ge  = trial >= {1'b0, r_den};
    assign trial_sub = trial - {1'b0, r_den};

    always_comb begin
        q_s    = r_neg ? -signed'({1'b0, r_quo}) : signed'({1'b0, r_quo});
        e_full = signed'({q_s[Q_W-1], q_s}) - E_HALF;
        if (r_fault) begin
            err_c = '0;
        end else if (e_full > E_HI) begin
            err_c = E_HI[ERR_W-1:0];
        end else if (e_full < E_LO) begin
            err_c = E_LO[ERR_W-1:0];
        end else begin
            err_c = e_full[ERR_W-1:0];
        end
    end

    always_comb begin
        s_full = signed'({{2{r_err_sum[SUM_W-1]}}, r_err_sum})
               + signed'({{(SUM_W+2-ERR_W){r_err[ERR_W-1]}}, r_err})
               + signed'({{(SUM_W+2-ERR_W){r_prev_err[ERR_W-1]}}, r_prev_err});
        if ((s_full[SUM_W+1:SUM_W-1] == 3'b000) || (s_full[SUM_W+1:SUM_W-1] == 3'b111)) begin
            sum_c = s_full[SUM_W-1:0];
        end else if (s_full[SUM_W+1]) begin
            sum_c = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            sum_c = {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    always_comb begin
        case (i_cmd.msel)
            MSEL_P: begin
                mul_a = signed'({1'b0, i_gain_p});
                mul_b = signed'({{(SUM_W-ERR_W){r_err[ERR_W-1]}}, r_err});
            end
            MSEL_I: begin
                mul_a = signed'({1'b0, i_gain_i});
                mul_b = r_err_sum;
            end
            MSEL_D: begin
                mul_a = signed'({1'b0, i_gain_d});
                mul_b = signed'({{(SUM_W-ERR_W-1){r_diff[ERR_W]}}, r_diff});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_c = mul_a * mul_b;
    end

    // bias negative values so the shift truncates toward zero
    assign acc_b = r_acc[ACC_W-1] ? (r_acc + RND_BIAS) : r_acc;

    always_comb begin
        if (r_q > S_HI) begin
            steer_c = S_HI[STEER_W-1:0];
        end else if (r_q < S_LO) begin
            steer_c = S_LO[STEER_W-1:0];
        end else begin
            steer_c = r_q[STEER_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_err_sum  <= '0;
            r_dark_run <= '0;
        end else begin
            if (i_cmd.load) begin
                if (is_dark) begin
                    if (!run_full) begin
                        r_dark_run <= run_inc;
                    end
                end else begin
                    r_dark_run <= '0;
                end
            end
            if (i_cmd.sum_calc) begin
                r_err_sum <= sum_c;
            end
            if (i_cmd.finish) begin
                r_prev_err <= r_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo   <= {num_mag, {Q16_SHIFT{1'b0}}};
            r_rem   <= '0;
            r_den   <= den_mag;
            r_neg   <= num_diff[LEVEL_W] ^ den_diff[LEVEL_W];
            r_fault <= (i_white_level == i_black_level);
            r_alert <= is_dark && !run_full && (run_inc == i_dark_run_length);
        end
        if (i_cmd.div_step) begin
            r_rem <= trial_ge ? trial_sub[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], trial_ge};
        end
        if (i_cmd.err_calc) begin
            r_err <= err_c;
        end
        if (i_cmd.sum_calc) begin
            r_diff <= signed'({r_err[ERR_W-1], r_err}) - signed'({r_prev_err[ERR_W-1], r_prev_err});
            r_acc  <= '0;
        end
        if (i_cmd.mul_en) begin
            r_prod <= prod_c;
        end
        if (i_cmd.acc_en) begin
            r_acc <= r_acc + signed'({r_prod[PROD_W-1], r_prod});
        end
        if (i_cmd.rnd) begin
            r_q <= acc_b[ACC_W-1:FRAC_W];
        end
        if (i_cmd.finish) begin
            r_steer     <= steer_c;
            r_alert_out <= r_alert;
            r_fault_out <= r_fault;
        end
    end

    assign o_steer       = r_steer;
    assign o_dark_alert  = r_alert_out;
    assign o_calib_fault = r_fault_out;

    `LFPS_ASSERT_RST(a_err_clamped, i_clk, i_rst_n, i_cmd.err_calc |=> (r_err <= ERR_MAX) && (r_err >= ERR_MIN))
    `LFPS_ASSERT_RST(a_fault_zero_err, i_clk, i_rst_n, i_cmd.err_calc && r_fault |=> r_err == '0)
    `LFPS_ASSERT_RST(a_steer_range, i_clk, i_rst_n, i_cmd.finish |=> (r_steer <= STR_MAX) && (r_steer >= STR_MIN))

endmodule
